@@ sv/salts_pkg.sv @@
// ----------------------------------------------------------------------------
// salts_pkg: shared types and constants for the set-associative LRU tag store
// Sizes of the store, field widths, register indexes and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package salts_pkg;

    // Store geometry
    localparam int MAX_WAYS = 16;
    localparam int MAX_SETS = 256;
    localparam int TAG_BITS = 48;

    // Derived widths
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;  // way number
    localparam int FILL_W = $clog2(MAX_WAYS + 1);                   // 0..MAX_WAYS
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;  // memory address

    // Fixed field widths of the stream items
    localparam int SET_IDX_BITS = 8;
    localparam int TAG_FLD_BITS = 48;
    localparam int WAYS_REG_W   = 5;
    localparam int SETS_REG_W   = 9;
    localparam int COUNT_W      = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS = 8'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

`default_nettype wire

@@ sv/salts_ram.sv @@
// ----------------------------------------------------------------------------
// salts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module salts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/set_assoc_lru_tag_store.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store: set-associative tag lookup with LRU ordering
// Looks up a tag in a set, reorders the set most-recent first, counts hits.
// ----------------------------------------------------------------------------
// On acceptance of an item, all ways of the set are read in parallel from one
// RAM per way (plus a per-set fill-count RAM); in the lookup state the tags are
// compared and, once the output register is free, the set is shifted and
// written back and the result is loaded into the output register. The next
// item is accepted in the cycle after the write-back, so a new item is not
// taken before the last one is through. A result may sit unread in the output
// register while the next item is accepted at no cost; if it still waits
// with m_tready low after that, the next lookup is held until it is taken.
// Way 0 of a set holds the most recently used tag. Empty sets are tracked by
// one flop per set cleared at reset, so there is no clearing pass. Configure
// ways_in_use (index 0) and sets_in_use (index 1) only while no item is in
// flight; 0 acts as 1 and values above the maximum act as the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_tag_store
    import salts_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // access items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [55:0]           s_tdata,   // set_index[7:0], tag[55:8]

    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [63:0]                m_tdata,   // hit_count[31:0], access_count[63:32]
    output logic [1:0]                 m_tuser,   // hit[0], bad_set[1]

    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic [WAYS_REG_W-1:0] ways_reg;
    logic [SETS_REG_W-1:0] sets_reg;
    logic [FILL_W-1:0]     ways_eff;
    logic [SETS_REG_W-1:0] sets_eff;

    logic [SET_IDX_BITS-1:0] in_set;
    logic [TAG_BITS-1:0]     in_tag;
    logic [SET_W-1:0]        in_addr;
    logic                    in_bad;
    logic                    accept;
    logic                    rd_en;
    logic                    go;

    logic [SET_W-1:0]    set_q;
    logic [TAG_BITS-1:0] tag_q;
    logic                bad_q;
    logic                row_valid_q;

    logic [MAX_SETS-1:0] row_valid_reg;

    logic [TAG_BITS-1:0] way_rd [MAX_WAYS];
    logic [TAG_BITS-1:0] way_wd [MAX_WAYS];
    logic [MAX_WAYS-1:0] way_we;

    logic [FILL_W-1:0] fill_rd;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_new;
    logic              fill_we;

    logic [FILL_W-1:0]   limit;
    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic [WAY_W-1:0]    hit_idx;
    logic [FILL_W-1:0]   last_way;
    logic [WAY_W-1:0]    pos;

    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] acc_next;

    logic out_valid_reg;
    logic out_hit_reg;
    logic out_bad_reg;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= WAYS_REG_W'(MAX_WAYS);
            sets_reg <= SETS_REG_W'(MAX_SETS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WAYS)
            begin
                ways_reg <= cfg_data[WAYS_REG_W-1:0];
            end
            else if (cfg_index == CFG_SETS)
            begin
                sets_reg <= cfg_data[SETS_REG_W-1:0];
            end
        end
    end

    // clamp registers into their usable range
    always_comb
    begin
        if (ways_reg == '0)
            ways_eff = FILL_W'(1);
        else if (ways_reg > WAYS_REG_W'(MAX_WAYS))
            ways_eff = FILL_W'(MAX_WAYS);
        else
            ways_eff = FILL_W'(ways_reg);

        if (sets_reg == '0)
            sets_eff = SETS_REG_W'(1);
        else if (sets_reg > SETS_REG_W'(MAX_SETS))
            sets_eff = SETS_REG_W'(MAX_SETS);
        else
            sets_eff = sets_reg;
    end

    // ------------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------------
    assign in_set  = s_tdata[SET_IDX_BITS-1:0];
    assign in_tag  = s_tdata[SET_IDX_BITS +: TAG_BITS];
    assign in_addr = in_set[SET_W-1:0];
    assign in_bad  = {1'b0, in_set} >= sets_eff;
    assign accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_tready = 1'b0;
        go       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_LOOKUP:
            begin
                go = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign rd_en = accept;

    // item held for the lookup cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_q       <= in_addr;
            tag_q       <= in_tag;
            bad_q       <= in_bad;
            row_valid_q <= row_valid_reg[in_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Per-set occupancy flags, cleared at reset
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (fill_we)
            row_valid_reg[set_q] <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Way RAMs and fill-count RAM
    // ------------------------------------------------------------------------
    for (genvar w = 0; w < MAX_WAYS; w++)
    begin : g_way
        salts_ram #(
            .WIDTH (TAG_BITS),
            .DEPTH (MAX_SETS)
        ) u_way_ram (
            .clk   (clk),
            .we    (way_we[w]),
            .waddr (set_q),
            .wdata (way_wd[w]),
            .re    (rd_en),
            .raddr (in_addr),
            .rdata (way_rd[w])
        );
    end

    salts_ram #(
        .WIDTH (FILL_W),
        .DEPTH (MAX_SETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (set_q),
        .wdata (fill_new),
        .re    (rd_en),
        .raddr (in_addr),
        .rdata (fill_rd)
    );

    // ------------------------------------------------------------------------
    // Tag compare over the occupied ways in use
    // ------------------------------------------------------------------------
    assign fill_cur = row_valid_q ? fill_rd : '0;
    assign limit    = (fill_cur < ways_eff) ? fill_cur : ways_eff;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            match[i] = (FILL_W'(i) < limit) && (way_rd[i] == tag_q);
        end
    end

    // first matching way wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = WAY_W'(i);
            end
        end
    end

    // slot vacated by the shift: the hit way, or the last way in use
    assign last_way = ways_eff - FILL_W'(1);
    assign pos      = hit ? hit_idx : last_way[WAY_W-1:0];

    // ------------------------------------------------------------------------
    // Shift and write back
    // ------------------------------------------------------------------------
    for (genvar w = 0; w < MAX_WAYS; w++)
    begin : g_wb
        assign way_we[w] = go && !bad_q && (WAY_W'(w) <= pos);
        if (w == 0)
        begin : g_front
            assign way_wd[w] = tag_q;
        end
        else
        begin : g_shift
            assign way_wd[w] = way_rd[w-1];
        end
    end

    assign fill_we  = go && !bad_q;
    assign fill_new = (!hit && (fill_cur < ways_eff)) ? fill_cur + FILL_W'(1) : fill_cur;

    // ------------------------------------------------------------------------
    // Saturating counters
    // ------------------------------------------------------------------------
    always_comb
    begin
        hits_next = hits_reg;
        acc_next  = acc_reg;
        if (go && !bad_q)
        begin
            if (acc_reg != COUNT_MAX)
                acc_next = acc_reg + COUNT_W'(1);
            if (hit && (hits_reg != COUNT_MAX))
                hits_next = hits_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
            acc_reg  <= acc_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output register; counters only move when a result loads, so they are
    // presented directly.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_hit_reg <= hit && !bad_q;
            out_bad_reg <= bad_q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {acc_reg, hits_reg};
    assign m_tuser  = {out_bad_reg, out_hit_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted item did not enter lookup");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result loaded outside lookup");

    a_set_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !bad_q) |=> row_valid_reg[$past(set_q)])
        else $error("written set not marked occupied");

    a_hits_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= acc_reg)
        else $error("hit count exceeds access count");

    a_hit_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_bad_reg))
        else $error("hit reported on a bad set");

endmodule

`default_nettype wire
